### hdl/bfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants and types of the beacon filter with proximity alert.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int          COUNT_MAX_DEF   = 255;

	localparam logic [7:0]  MFG_TYPE        = 8'hFF;
	localparam logic [7:0]  MIN_MFG_LEN     = 8'd6;
	localparam logic [2:0]  PATTERN_BYTES   = 3'd4;

	localparam logic [7:0]  PAT_BYTE0_RST   = 8'hC0;
	localparam logic [7:0]  PAT_BYTE1_RST   = 8'h04;
	localparam logic [7:0]  PAT_BYTE2_RST   = 8'hDA;
	localparam logic [7:0]  PAT_BYTE3_RST   = 8'hDA;

	localparam logic signed [7:0] RSSI_THR_RST    = -8'sd70;
	localparam logic [7:0]        SAMPLES_REQ_RST = 8'd3;

	localparam logic [1:0]  REG_RSSI_THRESHOLD   = 2'd0;
	localparam logic [1:0]  REG_SAMPLES_REQUIRED = 2'd1;
	localparam logic [1:0]  REG_BEACON_PATTERN   = 2'd2;

	typedef struct packed {
		logic       beacon_found;
		logic       alert_on;
		logic       alert_raised;
		logic [7:0] strong_count;
	} res_t;

endpackage

### hdl/beacon_filter_proximity_alert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_filter_proximity_alert
// Parses advertisement payload bytes, detects matching beacon packets and
// tracks a proximity alert from their RSSI.
// ----------------------------------------------------------------------------
// The block accepts one payload byte per clock cycle, without gaps, as long as
// the result side keeps up. Each accepted byte is registered; when it moves on,
// the structure walk takes it and, for a last byte, the alert counter updates
// and the result is registered in the output register; results appear only for
// last bytes. The output register lets a new byte enter while a result waits.
// Configuration takes effect from the next byte to move on; write it while the
// block is idle.
// ----------------------------------------------------------------------------
module beacon_filter_proximity_alert #(
	parameter int COUNT_MAX = bfpa_pkg::COUNT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] adv_byte, [15:8] rssi
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] alert_on, [1] alert_raised, [9:2] strong_count, zeros
	output logic        m_tuser,   // beacon_found
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	logic signed [7:0] thr_q;
	logic [7:0]        samples_q;
	logic [31:0]       pattern_q;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic signed [7:0] rssi_s1;
	logic              last_s1;

	logic              advance;
	logic              step;
	logic              found;
	logic              alert_q;
	logic [7:0]        count_q;
	bfpa_pkg::res_t    result;
	bfpa_pkg::res_t    res_q;
	logic              res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= bfpa_pkg::RSSI_THR_RST;
			samples_q <= bfpa_pkg::SAMPLES_REQ_RST;
			pattern_q <= {bfpa_pkg::PAT_BYTE3_RST, bfpa_pkg::PAT_BYTE2_RST,
			              bfpa_pkg::PAT_BYTE1_RST, bfpa_pkg::PAT_BYTE0_RST};
		end else if (cfg_we) begin
			case (cfg_idx)
				bfpa_pkg::REG_RSSI_THRESHOLD:   thr_q     <= cfg_data[7:0];
				bfpa_pkg::REG_SAMPLES_REQUIRED: samples_q <= cfg_data[7:0];
				bfpa_pkg::REG_BEACON_PATTERN:   pattern_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A registered byte moves on whenever the result register is free or drains.
	assign advance  = !res_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			rssi_s1 <= s_tdata[15:8];
			last_s1 <= s_tlast;
		end
	end

	bfpa_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (step),
		.adv_byte  (byte_s1),
		.last_byte (last_s1),
		.pattern   (pattern_q),
		.found     (found)
	);

	bfpa_alert #(
		.COUNT_MAX (COUNT_MAX)
	) u_alert (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (step && last_s1),
		.found            (found),
		.rssi             (rssi_s1),
		.thr_level        (thr_q),
		.samples_required (samples_q),
		.result           (result),
		.alert_q_out      (alert_q),
		.count_q_out      (count_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= result;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_q.beacon_found;
	assign m_tdata  = {6'd0, res_q.strong_count, res_q.alert_raised, res_q.alert_on};

	a_raised_on: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("alert raised without alert on");

	a_raised_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tuser)
		else $error("alert raised by a packet that was not a beacon");

	a_alert_count: assert property (@(posedge clk) disable iff (!arst_n)
		alert_q |-> count_q != 8'd0)
		else $error("alert active with zero strong count");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && res_valid_q && !m_tready)
		else $error("input stalled without a pending result");

endmodule

### hdl/bfpa_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_parser
// Walks the length-type structures of one advertisement payload, one byte
// per enabled cycle, and flags a complete matching manufacturer structure.
// ----------------------------------------------------------------------------
module bfpa_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  adv_byte,
	input  logic        last_byte,
	input  logic [31:0] pattern,
	output logic        found
);

	logic [7:0] pos_q, pos_n;
	logic [8:0] nss_q, nss_n;
	logic [7:0] len_q, len_n;
	logic       cand_q, cand_n;
	logic [2:0] matched_q, matched_n;
	logic       stopped_q, stopped_n;
	logic [8:0] pend_q, pend_n;
	logic       found_q, found_n;
	logic [7:0] want;
	logic       zero_stop;

	assign want = pattern[{matched_q[1:0], 3'b000} +: 8];

	always_comb begin
		pos_n     = pos_q;
		nss_n     = nss_q;
		len_n     = len_q;
		cand_n    = cand_q;
		matched_n = matched_q;
		stopped_n = stopped_q;
		pend_n    = pend_q;
		found_n   = found_q;
		zero_stop = 1'b0;

		if (!stopped_q && !found_q) begin
			if ({1'b0, pos_q} == nss_q) begin
				if (adv_byte == 8'd0) begin
					stopped_n = 1'b1;
					zero_stop = 1'b1;
				end else begin
					len_n     = adv_byte;
					nss_n     = {1'b0, pos_q} + {1'b0, adv_byte} + 9'd1;
					cand_n    = 1'b0;
					matched_n = 3'd0;
				end
			end else if (({1'b0, pos_q} + {1'b0, len_q}) == nss_q) begin
				// Type byte of the current structure.
				cand_n    = (adv_byte == bfpa_pkg::MFG_TYPE) && (len_q >= bfpa_pkg::MIN_MFG_LEN);
				matched_n = 3'd0;
			end else if (cand_q) begin
				if (adv_byte == want) begin
					matched_n = matched_q + 3'd1;
					if (matched_n >= bfpa_pkg::PATTERN_BYTES) begin
						pend_n = nss_q - 9'd1;
						cand_n = 1'b0;
					end
				end else begin
					cand_n = 1'b0;
				end
			end

			// The match only counts once the structure's final byte has arrived.
			if (!zero_stop && pend_n != 9'd0 && {1'b0, pos_q} == pend_n) begin
				found_n = 1'b1;
				pend_n  = 9'd0;
			end
		end

		found = found_n;

		if (!last_byte) begin
			if (pos_q == 8'd255) begin
				stopped_n = 1'b1;
			end else begin
				pos_n = pos_q + 8'd1;
			end
		end else begin
			pos_n     = 8'd0;
			nss_n     = 9'd0;
			len_n     = 8'd0;
			cand_n    = 1'b0;
			matched_n = 3'd0;
			stopped_n = 1'b0;
			pend_n    = 9'd0;
			found_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			nss_q     <= 9'd0;
			len_q     <= 8'd0;
			cand_q    <= 1'b0;
			matched_q <= 3'd0;
			stopped_q <= 1'b0;
			pend_q    <= 9'd0;
			found_q   <= 1'b0;
		end else if (en) begin
			pos_q     <= pos_n;
			nss_q     <= nss_n;
			len_q     <= len_n;
			cand_q    <= cand_n;
			matched_q <= matched_n;
			stopped_q <= stopped_n;
			pend_q    <= pend_n;
			found_q   <= found_n;
		end
	end

endmodule

### hdl/bfpa_alert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_alert
// Keeps the saturating count of strong beacon readings and the alert level,
// and forms the per-packet result.
// ----------------------------------------------------------------------------
module bfpa_alert #(
	parameter int COUNT_MAX = bfpa_pkg::COUNT_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               found,
	input  logic signed [7:0]  rssi,
	input  logic signed [7:0]  thr_level,
	input  logic [7:0]         samples_required,
	output bfpa_pkg::res_t     result,
	output logic               alert_q_out,
	output logic [7:0]         count_q_out
);

	localparam logic [7:0] LIMIT = (COUNT_MAX < 255) ? 8'(COUNT_MAX) : 8'd255;

	logic [7:0] cnt_q, cnt_n;
	logic       alert_q, alert_n;
	logic       raised;

	always_comb begin
		cnt_n   = cnt_q;
		alert_n = alert_q;
		raised  = 1'b0;
		if (found) begin
			if (rssi > thr_level) begin
				if (cnt_q < LIMIT) begin
					cnt_n = cnt_q + 8'd1;
				end
				if (cnt_n >= samples_required && !alert_q) begin
					alert_n = 1'b1;
					raised  = 1'b1;
				end
			end else if (cnt_q != 8'd0) begin
				cnt_n   = 8'd0;
				alert_n = 1'b0;
			end
		end
		result.beacon_found = found;
		result.alert_on     = alert_n;
		result.alert_raised = raised;
		result.strong_count = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 8'd0;
			alert_q <= 1'b0;
		end else if (en) begin
			cnt_q   <= cnt_n;
			alert_q <= alert_n;
		end
	end

	assign alert_q_out = alert_q;
	assign count_q_out = cnt_q;

endmodule
